>>> hdl/itfmt_pkg.sv
`default_nettype none

package itfmt_pkg;

    // Largest number of digits one item can produce.
    localparam int MAX_DIGITS = 16;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Reciprocal of ten for a 32-bit dividend: q = (x * DIV10_RECIP) >> DIV10_SHIFT.
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;

    // Conversion kinds.
    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_LHEX = 3'd2;
    localparam logic [2:0] CMD_UHEX = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;
    // Unused kinds, handled as unsigned decimal.
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ZERO = 2'd1;
    localparam logic [1:0] PREC_POS  = 2'd2;
    localparam logic [1:0] PREC_RSVD = 2'd3;

    localparam logic [1:0] SMODE_NONE  = 2'd0;
    localparam logic [1:0] SMODE_PLUS  = 2'd1;
    localparam logic [1:0] SMODE_SPACE = 2'd2;
    localparam logic [1:0] SMODE_RSVD  = 2'd3;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;
    localparam logic [1:0] SIGN_SPACE = 2'd3;

    localparam logic [1:0] PREFIX_NONE  = 2'd0;
    localparam logic [1:0] PREFIX_LOWER = 2'd1;
    localparam logic [1:0] PREFIX_UPPER = 2'd2;

    // Program addresses.
    typedef enum logic [2:0] {
        PC_IDLE  = 3'd0,
        PC_CLASS = 3'd1,
        PC_SPLIT = 3'd2,
        PC_DMUL  = 3'd3,
        PC_DDIG  = 3'd4,
        PC_EMIT  = 3'd5,
        PC_HDIG  = 3'd6,
        PC_EMPTY = 3'd7
    } pc_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_DDIG,
        OP_HDIG,
        OP_EMIT,
        OP_EMPTY
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_ACCEPT,
        COND_EMPTY,
        COND_HEX,
        COND_MORE,
        COND_DONE,
        COND_EMIT_DONE,
        COND_OUT_FREE
    } cond_t;

    // What happens when the condition is false.
    typedef enum logic {
        MISS_NEXT,
        MISS_STAY
    } miss_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        miss_t miss;
    } uword_t;

    // Status flags returned by the datapath to the sequencer.
    typedef struct packed {
        logic accept;
        logic empty;
        logic hex;
        logic more;
        logic emit_done;
        logic out_free;
    } status_t;

    // The microprogram.
    function automatic uword_t ucode_word(input pc_t pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE, miss: MISS_STAY};
        case (pc)
            PC_IDLE:  w = '{op: OP_LOAD,  cond: COND_ACCEPT,    target: PC_CLASS, miss: MISS_STAY};
            PC_CLASS: w = '{op: OP_NOP,   cond: COND_EMPTY,     target: PC_EMPTY, miss: MISS_NEXT};
            PC_SPLIT: w = '{op: OP_NOP,   cond: COND_HEX,       target: PC_HDIG,  miss: MISS_NEXT};
            PC_DMUL:  w = '{op: OP_MUL,   cond: COND_ALWAYS,    target: PC_DDIG,  miss: MISS_NEXT};
            PC_DDIG:  w = '{op: OP_DDIG,  cond: COND_MORE,      target: PC_DMUL,  miss: MISS_NEXT};
            PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_EMIT_DONE, target: PC_IDLE,  miss: MISS_STAY};
            PC_HDIG:  w = '{op: OP_HDIG,  cond: COND_DONE,      target: PC_EMIT,  miss: MISS_STAY};
            PC_EMPTY: w = '{op: OP_EMPTY, cond: COND_OUT_FREE,  target: PC_IDLE,  miss: MISS_STAY};
            default:  w = '{op: OP_NOP,   cond: COND_ALWAYS,    target: PC_IDLE,  miss: MISS_STAY};
        endcase
        return w;
    endfunction

    function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic upper);
        logic [6:0] ch;
        if (d < 4'd10) begin
            ch = CHAR_ZERO + {3'd0, d};
        end else begin
            ch = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {3'd0, d - 4'd10};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> hdl/integer_to_ascii_formatter_unit.sv
// Integer-to-ASCII formatter: the digit stage of a printf-style integer conversion.
// One input beat on the s_ channel carries an argument and a conversion kind; the
// block answers with one m_ beat per digit, most significant digit first, and
// m_tlast high on the final digit. A zero value with zero precision gives a single
// beat with no_digits set and a null character.
// Steps: after the input beat, the CLASS step classifies the item, the SPLIT
// step picks decimal or hex, then the digit loop runs. Hex makes a digit at each
// HDIG step; decimal makes each digit by a registered multiply by the reciprocal
// of ten (DMUL), then the remainder (DDIG). The emit step then moves one digit per
// cycle into the output register while that register is free. The next input beat
// is taken as soon as the last digit sits in the output register, so it overlaps
// the delivery of that last beat. Reset (aresetn low at a clock edge) returns the
// sequencer to its idle step and drops m_tvalid; no clearing pass is needed. When
// the receiver stalls, the output register holds its beat and the emit step simply
// waits; no digit is lost.
`default_nettype none

module integer_to_ascii_formatter_unit
    import itfmt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: value[63:0], precision_mode[65:64], alt_form[66],
    // sign_mode[68:67], zeros above.
    input  wire logic [71:0] s_tdata,
    // s_tuser: cmd[2:0].
    input  wire logic [2:0]  s_tuser,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, from bit 0: digit_char[6:0], no_digits[7], sign_char[9:8],
    // prefix_code[11:10], zero_pad_off[12], zeros above.
    output logic [15:0]      m_tdata,
    // m_tlast: last digit of the item.
    output logic             m_tlast
);

    // The sequencer fetches one control word per step and steers the datapath;
    // the datapath returns the flags the jumps test.
    op_t     op;
    status_t status;

    itfmt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    itfmt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/itfmt_sequencer.sv
`default_nettype none

module itfmt_sequencer
    import itfmt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire status_t status,
    output op_t          op
);

    pc_t    pc_reg, pc_next;
    uword_t word;
    logic   hit;

    // Control word fetch and output decode.
    always_comb begin
        word = ucode_word(pc_reg);
        op   = word.op;
    end

    // Condition select and next address.
    always_comb begin
        case (word.cond)
            COND_ALWAYS:    hit = 1'b1;
            COND_ACCEPT:    hit = status.accept;
            COND_EMPTY:     hit = status.empty;
            COND_HEX:       hit = status.hex;
            COND_MORE:      hit = status.more;
            COND_DONE:      hit = !status.more;
            COND_EMIT_DONE: hit = status.emit_done;
            COND_OUT_FREE:  hit = status.out_free;
            default:        hit = 1'b0;
        endcase
        if (hit) begin
            pc_next = word.target;
        end else if (word.miss == MISS_NEXT) begin
            pc_next = pc_t'(pc_reg + 3'd1);
        end else begin
            pc_next = pc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/itfmt_datapath.sv
`default_nettype none

module itfmt_datapath
    import itfmt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire op_t         op,
    output status_t          status,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    logic [2:0]  in_cmd;
    logic [63:0] in_value;
    logic [1:0]  in_prec;
    logic        in_alt;
    logic [1:0]  in_smode;
    logic [31:0] in_word;

    logic [63:0]      rem_reg, rem_next;
    logic [63:0]      prod_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       digits_reg [MAX_DIGITS];
    logic [1:0]       sign_reg, prefix_reg;
    logic             pad_off_reg, empty_reg, hex_reg, upper_reg;

    logic [1:0]  ld_sign, ld_prefix;
    logic        ld_hex, ld_upper;
    logic [63:0] ld_rem;

    logic [28:0]          quot;
    logic [31:0]          quot_x10;
    logic [3:0]           dec_digit;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     cnt_dec;
    logic [DIG_IDX_W-1:0] wr_idx, rd_idx;
    logic                 out_free, out_load;

    logic             m_valid_reg;
    logic [6:0]       m_char_reg;
    logic             m_nodig_reg;
    logic [1:0]       m_sign_reg, m_prefix_reg;
    logic             m_pad_reg, m_last_reg;

    assign in_cmd   = s_tuser;
    assign in_value = s_tdata[63:0];
    assign in_prec  = s_tdata[65:64];
    assign in_alt   = s_tdata[66];
    assign in_smode = s_tdata[68:67];
    assign in_word  = in_value[31:0];

    assign s_tready = (op == OP_LOAD);

    // Argument conditioning at load.
    always_comb begin
        ld_sign   = SIGN_NONE;
        ld_prefix = PREFIX_NONE;
        ld_hex    = 1'b0;
        ld_upper  = 1'b0;
        ld_rem    = {32'd0, in_word};
        case (in_cmd)
            CMD_SDEC: begin
                if (in_word[31]) begin
                    ld_rem  = {32'd0, (~in_word) + 32'd1};
                    ld_sign = SIGN_MINUS;
                end else if (in_smode == SMODE_PLUS) begin
                    ld_sign = SIGN_PLUS;
                end else if (in_smode == SMODE_SPACE) begin
                    ld_sign = SIGN_SPACE;
                end
            end
            CMD_LHEX, CMD_UHEX: begin
                ld_hex   = 1'b1;
                ld_upper = (in_cmd == CMD_UHEX);
                if (in_alt && (in_word != 32'd0)) begin
                    ld_prefix = (in_cmd == CMD_UHEX) ? PREFIX_UPPER : PREFIX_LOWER;
                end
            end
            CMD_PTR: begin
                ld_hex    = 1'b1;
                ld_prefix = PREFIX_LOWER;
                ld_rem    = in_value;
            end
            default: begin
                ld_rem = {32'd0, in_word};
            end
        endcase
    end

    // Decimal digit from the registered reciprocal product.
    assign quot      = prod_reg[63:DIV10_SHIFT];
    assign quot_x10  = {quot, 3'd0} + {2'd0, quot, 1'b0};
    assign dec_digit = 4'(rem_reg[31:0] - quot_x10);

    assign cnt_inc  = count_reg + CNT_W'(1);
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign wr_idx   = count_reg[DIG_IDX_W-1:0];
    assign rd_idx   = cnt_dec[DIG_IDX_W-1:0];
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && ((op == OP_EMIT) || (op == OP_EMPTY));

    always_comb begin
        rem_next   = rem_reg;
        count_next = count_reg;
        case (op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    rem_next   = ld_rem;
                    count_next = '0;
                end
            end
            OP_DDIG: begin
                rem_next   = {35'd0, quot};
                count_next = cnt_inc;
            end
            OP_HDIG: begin
                rem_next   = {4'd0, rem_reg[63:4]};
                count_next = cnt_inc;
            end
            OP_EMIT: begin
                if (out_free) begin
                    count_next = cnt_dec;
                end
            end
            default: begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_comb begin
        status.accept    = s_tvalid && s_tready;
        status.empty     = empty_reg;
        status.hex       = hex_reg;
        status.more      = (cnt_inc < CNT_W'(MAX_DIGITS)) &&
                           ((op == OP_HDIG) ? (rem_reg[63:4] != 60'd0) : (quot != 29'd0));
        status.emit_done = out_free && (count_reg == CNT_W'(1));
        status.out_free  = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            count_reg <= '0;
        end else begin
            rem_reg   <= rem_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_LOAD && s_tvalid) begin
            sign_reg    <= ld_sign;
            prefix_reg  <= ld_prefix;
            hex_reg     <= ld_hex;
            upper_reg   <= ld_upper;
            pad_off_reg <= (in_prec != PREC_NONE);
            empty_reg   <= (ld_rem == 64'd0) && (in_prec == PREC_ZERO);
        end
        if (op == OP_MUL) begin
            prod_reg <= 64'(rem_reg[31:0]) * 64'(DIV10_RECIP);
        end
        if (op == OP_DDIG) begin
            digits_reg[wr_idx] <= dec_digit;
        end else if (op == OP_HDIG) begin
            digits_reg[wr_idx] <= rem_reg[3:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sign_reg   <= sign_reg;
            m_prefix_reg <= prefix_reg;
            m_pad_reg    <= pad_off_reg;
            if (op == OP_EMPTY) begin
                m_char_reg  <= 7'd0;
                m_nodig_reg <= 1'b1;
                m_last_reg  <= 1'b1;
            end else begin
                m_char_reg  <= digit_to_char(digits_reg[rd_idx], upper_reg);
                m_nodig_reg <= 1'b0;
                m_last_reg  <= (count_reg == CNT_W'(1));
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'd0, m_pad_reg, m_prefix_reg, m_sign_reg, m_nodig_reg, m_char_reg};

endmodule

`default_nettype wire
